// File: design/fpll_pkg.sv
// Shared types and constants for the flux PLL bit decoder.
package fpll_pkg;

  localparam logic [1:0] CFG_SAMPLE_CLOCK = 2'd0;
  localparam logic [1:0] CFG_BIT_RATE     = 2'd1;
  localparam logic [1:0] CFG_REVOLUTION   = 2'd2;

  localparam logic [1:0] DIV_NOM = 2'd0;
  localparam logic [1:0] DIV_EST = 2'd1;
  localparam logic [1:0] DIV_INC = 2'd2;

  localparam logic signed [35:0] PH_ONE = 36'sh001000000;
  localparam logic signed [35:0] PH_1P5 = 36'sh001800000;
  localparam logic signed [35:0] PH_1P6 = 36'sh00199999A;
  localparam logic signed [35:0] PH_1P4 = 36'sh001666666;
  localparam logic [63:0] INC_CAP = 64'h0000_0000_4000_0000;
  localparam logic [30:0] ADJ_DN  = 31'd1073204953;
  localparam logic [30:0] ADJ_UP  = 31'd1074278695;
  // ceil(2^35 / 10): product >> 35 gives an exact divide by ten for 32-bit values
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic [31:0] RST_SAMPLE_CLOCK = 32'd24000000;
  localparam logic [23:0] RST_BIT_RATE     = 24'd500000;
  localparam logic [7:0]  RST_REVOLUTION   = 8'd1;
  localparam logic [31:0] RST_NOMINAL      = 32'd3145728;
  localparam logic [31:0] RST_LO           = 32'd2831155;
  localparam logic [31:0] RST_HI           = 32'd3460300;

  typedef struct packed {
    logic       cfg_we;
    logic       in_take;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_cap;
    logic       lim_mul;
    logic       lim_fin;
    logic       emit;
    logic       mul_go;
    logic       adj_fin;
  } fpll_cmd_t;

  typedef struct packed {
    logic div_done;
    logic run_item;
    logic run_more;
    logic out_free;
    logic cfg_reload;
  } fpll_stat_t;

endpackage

// File: design/flux_pll_bit_decoder.sv
// Top level: floppy flux interval to cell bit decoder with adaptive digital PLL.
// An item that yields bits runs two bit-serial divisions (rate estimate, phase increment),
//   then emits its bits, holding while out stalls, and adjusts the cell period before the
//   next accept.
// Index-only or ignored items are taken without leaving idle. A sample_clock or bit_rate
//   write runs one division plus the limit multiply before the next accept.
// Reset (synchronous) loads default registers and the matching periods at once.
module flux_pll_bit_decoder import fpll_pkg::*; #(
  parameter int MAX_BITS_PER_PULSE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] flux_interval,
  input  logic        index_event,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        bit_value,
  output logic        weak_bit,
  output logic [31:0] rate_estimate,
  output logic        restart_mark,
  output logic        index_mark,
  output logic        last_of_run
);

  fpll_cmd_t  cmd;
  fpll_stat_t stat;

  fpll_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .in_valid(in_valid), .in_ready(in_ready), .stat(stat), .cmd(cmd)
  );

  fpll_dp #(.MAX_BITS_PER_PULSE(MAX_BITS_PER_PULSE)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .flux_interval(flux_interval), .index_event(index_event),
    .out_valid(out_valid), .out_ready(out_ready),
    .bit_value(bit_value), .weak_bit(weak_bit), .rate_estimate(rate_estimate),
    .restart_mark(restart_mark), .index_mark(index_mark), .last_of_run(last_of_run)
  );

endmodule

// File: design/fpll_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module fpll_div import fpll_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [31:0] rem;
  logic [63:0] dq;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] rem_s;
  logic        fits;

  assign rem_s    = {rem, dq[63]};
  assign fits     = rem_s >= {1'b0, divisor};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= fits ? 32'(rem_s - {1'b0, divisor}) : rem_s[31:0];
      dq  <= {dq[62:0], fits};
    end
  end

endmodule

// File: design/fpll_dp.sv
// Datapath: registers, divider, phase accumulator, period adjust and output stage.
module fpll_dp import fpll_pkg::*; #(
  parameter int MAX_BITS_PER_PULSE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  fpll_cmd_t   cmd,
  output fpll_stat_t  stat,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [23:0] flux_interval,
  input  logic        index_event,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        bit_value,
  output logic        weak_bit,
  output logic [31:0] rate_estimate,
  output logic        restart_mark,
  output logic        index_mark,
  output logic        last_of_run
);

  localparam int NW = $clog2(MAX_BITS_PER_PULSE);

  logic [31:0] sample_clock;
  logic [23:0] bit_rate;
  logic [7:0]  revolution;
  logic [31:0] nominal_period, lo_lim, hi_lim, cell_period, phase_accum, est;
  logic [1:0]  weak_shift;
  logic [15:0] index_count;
  logic        pending_restart, pending_index, stopped;
  logic [23:0] flux_val;
  logic signed [35:0] p_work;
  logic [NW-1:0] n_count;
  logic [62:0] prod;

  logic [63:0] div_a, q;
  logic [31:0] div_b;
  logic        div_done;
  logic [31:0] q_sat;

  fpll_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(q)
  );

  assign q_sat = (q[63:32] != 32'd0) ? 32'hFFFF_FFFF : q[31:0];

  always_comb begin
    div_a = {16'd0, sample_clock, 16'd0};
    div_b = cell_period;
    case (cmd.div_sel)
      DIV_NOM: div_b = (bit_rate == 24'd0) ? 32'd1 : {8'd0, bit_rate};
      DIV_EST: div_b = cell_period;
      DIV_INC: div_a = {flux_val, 40'd0};
      default: div_b = cell_period;
    endcase
  end

  // period limits: floor(nominal/10) by reciprocal multiply,
  // lo = nominal - ceil(nominal/10), hi = nominal + floor(nominal/10)
  logic [63:0] lim_prod;
  logic [31:0] q10;
  logic [34:0] q10x10;
  logic        rem_nz;
  logic [31:0] lo_v;
  logic [32:0] hi_v;

  assign q10    = {3'd0, lim_prod[63:35]};
  assign q10x10 = {q10, 3'b0} + {2'b0, q10, 1'b0};
  assign rem_nz = q10x10 != {3'd0, nominal_period};
  assign lo_v   = nominal_period - q10 - {31'd0, rem_nz};
  assign hi_v   = {1'b0, nominal_period} + {1'b0, q10};

  // index bookkeeping for the item at the input
  logic        is_idx;
  logic [15:0] cnt_new;
  logic [15:0] rev_e;
  logic        hit_rev, hit_next, stop_now;

  assign is_idx   = (flux_interval == 24'd0) || index_event;
  assign cnt_new  = (index_count == 16'hFFFF) ? index_count : index_count + 16'd1;
  assign rev_e    = (revolution == 8'd0) ? 16'd1 : {8'd0, revolution};
  assign hit_rev  = cnt_new == rev_e;
  assign hit_next = cnt_new == rev_e + 16'd1;
  assign stop_now = is_idx && (cnt_new > rev_e + 16'd1);

  logic signed [35:0] p_clamp;
  logic [1:0]  weak_zero, weak_one;
  logic [30:0] inc_v;
  logic [32:0] c_adj;
  logic        out_free;
  logic        run_more_w;

  assign run_more_w = (p_work > PH_1P5) && (n_count < NW'(MAX_BITS_PER_PULSE - 1));
  assign p_clamp   = (p_work > PH_1P5) ? PH_1P5 : p_work;
  assign weak_zero = (p_work < PH_1P6) ? 2'b11 : weak_shift;
  assign weak_one  = (p_clamp > PH_1P4) ? 2'b11 : weak_shift;
  assign inc_v     = (q > INC_CAP) ? INC_CAP[30:0] : q[30:0];
  assign c_adj     = prod[62:30];
  assign out_free  = !out_valid || out_ready;

  assign stat.div_done   = div_done;
  assign stat.run_item   = !stopped && !stop_now && (flux_interval != 24'd0);
  assign stat.run_more   = run_more_w;
  assign stat.out_free   = out_free;
  assign stat.cfg_reload = (cfg_index == CFG_SAMPLE_CLOCK) || (cfg_index == CFG_BIT_RATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_clock    <= RST_SAMPLE_CLOCK;
      bit_rate        <= RST_BIT_RATE;
      revolution      <= RST_REVOLUTION;
      nominal_period  <= RST_NOMINAL;
      lo_lim          <= RST_LO;
      hi_lim          <= RST_HI;
      cell_period     <= RST_NOMINAL;
      phase_accum     <= '0;
      weak_shift      <= '0;
      index_count     <= '0;
      pending_restart <= 1'b0;
      pending_index   <= 1'b0;
      stopped         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_CLOCK: sample_clock <= cfg_data;
          CFG_BIT_RATE:     bit_rate <= cfg_data[23:0];
          CFG_REVOLUTION:   revolution <= cfg_data[7:0];
          default:          ;
        endcase
      end
      if (cmd.in_take && !stopped && is_idx) begin
        index_count <= cnt_new;
        if (hit_rev) pending_restart <= 1'b1;
        else if (hit_next) pending_index <= 1'b1;
        else if (stop_now) stopped <= 1'b1;
      end
      if (cmd.div_cap && div_done) begin
        case (cmd.div_sel)
          DIV_NOM: begin
            nominal_period <= (q_sat == 32'd0) ? 32'd1 : q_sat;
            cell_period    <= (q_sat == 32'd0) ? 32'd1 : q_sat;
          end
          default: ;
        endcase
      end
      if (cmd.lim_fin) begin
        lo_lim <= (lo_v == 32'd0) ? 32'd1 : lo_v;
        hi_lim <= hi_v[32] ? 32'hFFFF_FFFF : hi_v[31:0];
      end
      if (cmd.emit) begin
        out_valid       <= 1'b1;
        weak_shift      <= run_more_w ? (weak_zero >> 1) : (weak_one >> 1);
        pending_restart <= 1'b0;
        pending_index   <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.adj_fin) begin
        if (p_work < 0)
          cell_period <= (c_adj < {1'b0, lo_lim}) ? lo_lim : c_adj[31:0];
        else if (p_work > 0)
          cell_period <= (c_adj > {1'b0, hi_lim}) ? hi_lim : c_adj[31:0];
        phase_accum <= 32'(p_work >>> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_take) flux_val <= flux_interval;
    if (cmd.lim_mul) lim_prod <= nominal_period * RECIP10;
    if (cmd.div_cap && div_done) begin
      if (cmd.div_sel == DIV_EST) est <= q_sat;
      if (cmd.div_sel == DIV_INC) begin
        p_work  <= {{4{phase_accum[31]}}, phase_accum} + {5'd0, inc_v};
        n_count <= '0;
      end
    end
    if (cmd.emit) begin
      bit_value     <= !run_more_w;
      weak_bit      <= run_more_w ? weak_zero[0] : weak_one[0];
      rate_estimate <= est;
      restart_mark  <= pending_restart;
      index_mark    <= pending_index;
      last_of_run   <= !run_more_w;
      if (run_more_w) begin
        p_work  <= p_work - PH_ONE;
        n_count <= n_count + NW'(1);
      end else begin
        p_work <= p_clamp - PH_ONE;
      end
    end
    if (cmd.mul_go)
      prod <= cell_period * ((p_work < 0) ? ADJ_DN : ADJ_UP);
  end

  a_cell_nonzero: assert property (@(posedge clk) disable iff (rst) cell_period != 32'd0)
    else $error("cell period reached zero");
  a_emit_room: assert property (@(posedge clk) disable iff (rst) cmd.emit |-> out_free)
    else $error("bit emitted over a waiting beat");
  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    n_count <= NW'(MAX_BITS_PER_PULSE - 1))
    else $error("zero run exceeded cap");

endmodule

// File: design/fpll_ctrl.sv
// Controller state machine sequencing config loads, divisions, bit runs and period adjust.
module fpll_ctrl import fpll_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       in_valid,
  output logic       in_ready,
  input  fpll_stat_t stat,
  output fpll_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NOM_GO  = 4'd1;
  localparam logic [3:0] S_NOM_WT  = 4'd2;
  localparam logic [3:0] S_LIM_MUL = 4'd3;
  localparam logic [3:0] S_LIM_FIN = 4'd4;
  localparam logic [3:0] S_EST_GO  = 4'd5;
  localparam logic [3:0] S_EST_WT  = 4'd6;
  localparam logic [3:0] S_INC_GO  = 4'd7;
  localparam logic [3:0] S_INC_WT  = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;
  localparam logic [3:0] S_MUL     = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0] state, state_next;

  assign cfg_ready = state == S_IDLE;
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_NOM;
    case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_we = 1'b1;
          if (stat.cfg_reload) state_next = S_NOM_GO;
        end else if (in_valid) begin
          cmd.in_take = 1'b1;
          if (stat.run_item) state_next = S_EST_GO;
        end
      end
      S_NOM_GO: begin cmd.div_start = 1'b1; state_next = S_NOM_WT; end
      S_NOM_WT: begin
        cmd.div_cap = 1'b1;
        if (stat.div_done) state_next = S_LIM_MUL;
      end
      S_LIM_MUL: begin cmd.lim_mul = 1'b1; state_next = S_LIM_FIN; end
      S_LIM_FIN: begin cmd.lim_fin = 1'b1; state_next = S_IDLE; end
      S_EST_GO: begin
        cmd.div_sel = DIV_EST; cmd.div_start = 1'b1; state_next = S_EST_WT;
      end
      S_EST_WT: begin
        cmd.div_sel = DIV_EST;
        cmd.div_cap = 1'b1;
        if (stat.div_done) state_next = S_INC_GO;
      end
      S_INC_GO: begin
        cmd.div_sel = DIV_INC; cmd.div_start = 1'b1; state_next = S_INC_WT;
      end
      S_INC_WT: begin
        cmd.div_sel = DIV_INC;
        cmd.div_cap = 1'b1;
        if (stat.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        // hold while the previous beat waits
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.run_more) state_next = S_MUL;
        end
      end
      S_MUL: begin cmd.mul_go = 1'b1; state_next = S_FIN; end
      S_FIN: begin cmd.adj_fin = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_one_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !cmd.div_start)
    else $error("divider restarted back to back");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.in_take || cmd.cfg_we) |-> (state == S_IDLE))
    else $error("beat taken while busy");
  a_no_both: assert property (@(posedge clk) disable iff (rst) !(cmd.in_take && cmd.cfg_we))
    else $error("input and config taken together");

endmodule

// File: verif/flux_pll_bit_decoder_tb.sv
// Self-checking testbench for the flux PLL bit decoder: directed table, then random flux traffic.
module flux_pll_bit_decoder_tb import fpll_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUN = 64;
  localparam longint ONE_CELL = 64'h1000000;
  localparam longint HALF_UP = 64'h1800000;
  localparam longint NEAR_HI = 64'h199999A;
  localparam longint NEAR_LO = 64'h1666666;
  localparam longint RUN_CAP = 64'h40000000;
  localparam logic [63:0] NUDGE_DN = 64'd1073204953;
  localparam logic [63:0] NUDGE_UP = 64'd1074278695;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE = 300;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        bit_value;
    logic        weak_bit;
    logic [31:0] rate_estimate;
    logic        restart_mark;
    logic        index_mark;
    logic        last_of_run;
  } cell_bit_t;

  typedef struct {
    logic [23:0] iv;
    logic        ie;
    bit          known;
    int          n_bits;
    logic [31:0] est;
  } flux_row_t;

  logic        clk = 0, rst = 1;
  logic        cfg_valid = 0, cfg_ready;
  logic [1:0]  cfg_index = CFG_SAMPLE_CLOCK;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 0, in_ready;
  logic [23:0] flux_interval = '0;
  logic        index_event = 0;
  logic        out_valid, out_ready = 0;
  logic        bit_value, weak_bit, restart_mark, index_mark, last_of_run;
  logic [31:0] rate_estimate;

  flux_pll_bit_decoder uut (.*);

  // predictor state
  logic [31:0] m_sclk, m_rate, m_rev, m_cell, m_nom, m_phase;
  logic [1:0]  m_weak;
  logic [15:0] m_idx_cnt;
  bit          m_restart, m_index, m_stopped;

  cell_bit_t expected_bits[$];
  bit        failed = 0;
  longint    cycles = 0;
  int        send_idle = 0, recv_idle = 0;
  int        hold_asks = 0, hold_seen = 0, hold_left = 0;
  int        items_sent = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("flux_pll_bit_decoder_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
  endfunction

  function automatic void reload_nominal();
    logic [63:0] r, n;
    r = (m_rate == 0) ? 64'd1 : {32'd0, m_rate};
    n = {m_sclk, 16'd0} / r;
    m_nom = sat32(n);
    if (m_nom == 0) m_nom = 1;
    m_cell = m_nom;
  endfunction

  function automatic void model_reset();
    m_sclk = 24000000;
    m_rate = 500000;
    m_rev = 1;
    reload_nominal();
    m_phase = 0; m_weak = 0; m_idx_cnt = 0;
    m_restart = 0; m_index = 0; m_stopped = 0;
  endfunction

  function automatic void model_write(logic [1:0] idx, logic [31:0] d);
    case (idx)
      CFG_SAMPLE_CLOCK: begin m_sclk = d; reload_nominal(); end
      CFG_BIT_RATE: begin m_rate = {8'd0, d[23:0]}; reload_nominal(); end
      CFG_REVOLUTION: m_rev = {24'd0, d[7:0]};
      default: ;
    endcase
  endfunction

  function automatic void emit_bit(logic v, logic [31:0] est, logic last);
    cell_bit_t b;
    b.bit_value = v; b.weak_bit = m_weak[0]; b.rate_estimate = est;
    b.restart_mark = m_restart; b.index_mark = m_index; b.last_of_run = last;
    expected_bits.push_back(b);
    m_weak = m_weak >> 1;
    m_restart = 0; m_index = 0;
  endfunction

  // returns number of bits the flux interval decodes into
  function automatic int decode_flux(logic [23:0] iv, logic ie);
    logic [31:0] cper, est, rev;
    logic [63:0] inc, lo, hi, c;
    longint p;
    int n;
    n = 0;
    if (m_stopped) return 0;
    cper = (m_cell == 0) ? 32'd1 : m_cell;
    if (iv == 0 || ie) begin
      rev = (m_rev == 0) ? 32'd1 : m_rev;
      if (m_idx_cnt != 16'hFFFF) m_idx_cnt++;
      if (m_idx_cnt == rev) m_restart = 1;
      else if (m_idx_cnt == rev + 1) m_index = 1;
      else if (m_idx_cnt > rev + 1) begin
        m_stopped = 1;
        return 0;
      end
    end
    if (iv == 0) return 0;
    est = sat32({m_sclk, 16'd0} / cper);
    inc = {iv, 40'd0} / cper;
    if (inc > RUN_CAP) inc = RUN_CAP;
    p = longint'(signed'(m_phase)) + longint'(inc);
    while (p > HALF_UP && n < MAX_RUN - 1) begin
      if (p < NEAR_HI) m_weak = 2'b11;
      emit_bit(1'b0, est, 1'b0);
      n++;
      p -= ONE_CELL;
    end
    if (p > HALF_UP) p = HALF_UP;
    if (p > NEAR_LO) m_weak = 2'b11;
    emit_bit(1'b1, est, 1'b1);
    n++;
    p -= ONE_CELL;
    lo = {32'd0, m_nom} * 9 / 10;
    if (lo == 0) lo = 1;
    hi = {32'd0, sat32({32'd0, m_nom} * 11 / 10)};
    if (hi == 0) hi = 1;
    if (p < 0) begin
      c = ({32'd0, cper} * NUDGE_DN) >> 30;
      if (c < lo) c = lo;
      m_cell = sat32(c);
    end else if (p > 0) begin
      c = ({32'd0, cper} * NUDGE_UP) >> 30;
      if (c > hi) c = hi;
      m_cell = sat32(c);
    end
    if (p < 0) p = -((-p + 1) / 2);
    else p = p / 2;
    m_phase = p[31:0];
    return n;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    model_write(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_idling();
    if (items_sent < 170) begin send_idle = 22; recv_idle = 66; end
    else if (items_sent < 340) begin send_idle = 66; recv_idle = 22; end
    else begin send_idle = 0; recv_idle = 0; end
  endtask

  // valid stays up after a beat; the next call or drain() decides what follows
  task automatic send_flux(logic [23:0] iv, logic ie, output int n);
    set_idling();
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; flux_interval <= iv; index_event <= ie;
    do @(posedge clk); while (!in_ready);
    n = decode_flux(iv, ie);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_flux(int count);
    logic [31:0] ticks;
    logic [63:0] v;
    logic [23:0] iv;
    logic ie;
    int r, n;
    ticks = m_sclk / ((m_rate[23:0] == 0) ? 32'd1 : m_rate);
    if (ticks == 0) ticks = 1;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 75) begin
        v = 64'(ticks) * $urandom_range(2, 4) + $urandom_range(0, ticks / 4);
        v = v - ticks / 8;
        iv = (v > 64'hFFFFFF) ? 24'hFFFFFF : (v == 0) ? 24'd1 : v[23:0];
      end else if (r < 92) iv = 24'($urandom);
      else if (r < 99) iv = 24'($urandom_range(1, (ticks > 64'hFFFFFF) ? 32'hFFFFFF : ticks));
      else iv = 0;
      ie = ($urandom_range(149) == 0);
      send_flux(iv, ie, n);
    end
  endtask

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 0;
    end else if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cell_bit_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bits.size() == 0) begin
        $error("unexpected bit: bit_value=%0b", bit_value);
        failed = 1;
      end else begin
        want = expected_bits.pop_front();
        if (bit_value !== want.bit_value) begin
          $error("bit_value exp %0b got %0b", want.bit_value, bit_value); failed = 1;
        end
        if (weak_bit !== want.weak_bit) begin
          $error("weak_bit exp %0b got %0b", want.weak_bit, weak_bit); failed = 1;
        end
        if (rate_estimate !== want.rate_estimate) begin
          $error("rate_estimate exp %0d got %0d", want.rate_estimate, rate_estimate);
          failed = 1;
        end
        if (restart_mark !== want.restart_mark) begin
          $error("restart_mark exp %0b got %0b", want.restart_mark, restart_mark); failed = 1;
        end
        if (index_mark !== want.index_mark) begin
          $error("index_mark exp %0b got %0b", want.index_mark, index_mark); failed = 1;
        end
        if (last_of_run !== want.last_of_run) begin
          $error("last_of_run exp %0b got %0b", want.last_of_run, last_of_run); failed = 1;
        end
      end
    end
  end

  flux_row_t dir_rows[] = '{
    '{24'd96, 1'b0, 1'b1, 2, 32'd500000},
    '{24'd48, 1'b0, 1'b0, 0, 32'd0},
    '{24'd72, 1'b0, 1'b0, 0, 32'd0},
    '{24'd0, 1'b1, 1'b1, 0, 32'd0},
    '{24'd144, 1'b0, 1'b0, 0, 32'd0},
    '{24'd1, 1'b0, 1'b0, 0, 32'd0},
    '{24'hFFFFFF, 1'b0, 1'b0, 0, 32'd0},
    '{24'd100, 1'b1, 1'b0, 0, 32'd0},
    '{24'd76, 1'b0, 1'b0, 0, 32'd0},
    '{24'd77, 1'b0, 1'b0, 0, 32'd0},
    '{24'd70, 1'b0, 1'b0, 0, 32'd0},
    '{24'd50, 1'b0, 1'b0, 0, 32'd0},
    '{24'd46, 1'b0, 1'b0, 0, 32'd0},
    '{24'd120, 1'b0, 1'b0, 0, 32'd0},
    '{24'h555555, 1'b0, 1'b0, 0, 32'd0},
    '{24'hAAAAAA, 1'b0, 1'b0, 0, 32'd0}
  };

  initial begin
    int n;
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_flux(dir_rows[i].iv, dir_rows[i].ie, n);
      if (dir_rows[i].known && n !== dir_rows[i].n_bits) begin
        $error("row %0d: bits exp %0d got %0d", i, dir_rows[i].n_bits, n);
        failed = 1;
      end
      if (dir_rows[i].known && n > 0 &&
          expected_bits[expected_bits.size() - 1].rate_estimate !== dir_rows[i].est) begin
        $error("row %0d: rate_estimate exp %0d got %0d", i, dir_rows[i].est,
               expected_bits[expected_bits.size() - 1].rate_estimate);
        failed = 1;
      end
    end
    drain();

    // park far away so index events do not stop the block early
    write_reg(CFG_REVOLUTION, 32'd255);
    random_flux(60);
    hold_asks++;
    random_flux(25);
    drain();
    random_flux(60);

    drain();
    write_reg(CFG_SAMPLE_CLOCK, 32'hFFFFFFFF);
    write_reg(CFG_BIT_RATE, 32'd1);
    random_flux(25);
    drain();
    write_reg(CFG_SAMPLE_CLOCK, 32'd1);
    write_reg(CFG_BIT_RATE, 32'hFFFFFF);
    random_flux(25);
    drain();
    write_reg(CFG_SAMPLE_CLOCK, 32'd8000000);
    write_reg(CFG_BIT_RATE, 32'd0);
    random_flux(20);
    drain();
    write_reg(CFG_SAMPLE_CLOCK, 32'd48000000);
    write_reg(CFG_BIT_RATE, 32'd250000);
    random_flux(80);
    drain();
    write_reg(CFG_SAMPLE_CLOCK, $urandom_range(4000000, 80000000));
    write_reg(CFG_BIT_RATE, $urandom_range(125000, 1000000));
    hold_asks++;
    random_flux(150);
    drain();

    // drop to revolution 1: next index ends collection, later beats are ignored
    write_reg(CFG_REVOLUTION, 32'd0);
    send_flux(24'd0, 1'b1, n);
    for (int i = 0; i < 6; i++) send_flux(24'($urandom), 1'($urandom_range(1)), n);
    drain();

    if (!failed) $display("flux_pll_bit_decoder_tb: done, clean");
    else $display("flux_pll_bit_decoder_tb: done, errors");
    $finish;
  end

endmodule

// File: flux_pll_bit_decoder.f
design/fpll_pkg.sv
design/fpll_div.sv
design/fpll_dp.sv
design/fpll_ctrl.sv
design/flux_pll_bit_decoder.sv
verif/flux_pll_bit_decoder_tb.sv
